// File: rtl/dds_tone_and_pcm_dac_feeder_core_macros.svh
// Assertion macros for the DDS tone and PCM DAC feeder core.
`ifndef DDS_TONE_AND_PCM_DAC_FEEDER_CORE_MACROS_SVH
`define DDS_TONE_AND_PCM_DAC_FEEDER_CORE_MACROS_SVH
`ifndef SYNTH
`define DTPF_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtpf check failed");
`define DTPF_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtpf check failed");
`else
`define DTPF_CHECK(label, ante, cons)
`define DTPF_CHECK_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/dtpf_pkg.sv
// Shared types, codes and conversion functions of the DDS tone and PCM DAC feeder.
package dtpf_pkg;

  localparam logic [11:0] DAC_MID = 12'd2048;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_WRITE = 2'd3
  } dtpf_req_t;

  typedef enum logic [2:0] {
    CFG_PLAY_MODE   = 3'd0,
    CFG_PHASE_INC   = 3'd1,
    CFG_TONE_COUNT  = 3'd2,
    CFG_WAVE_BYTES  = 3'd3,
    CFG_STEREO      = 3'd4
  } dtpf_cfg_idx_t;

  typedef struct packed {
    logic        use_table;
    logic [11:0] code;
    logic        tone_done;
    logic        wave_done;
    logic        busy;
  } dtpf_s1_t;

  typedef struct packed {
    logic tone_active;
    logic wave_active;
    logic s1_valid;
  } dtpf_status_t;

  function automatic logic [11:0] to_dac12(input logic [15:0] s);
    return {~s[15], s[14:4]};
  endfunction

  function automatic logic [15:0] avg_trunc(input logic [15:0] l, input logic [15:0] r);
    logic [16:0] sum;
    logic [16:0] adj;
    sum = {l[15], l} + {r[15], r};
    adj = sum + {16'd0, sum[16] & sum[0]};
    return adj[16:1];
  endfunction

endpackage

// File: rtl/dtpf_table.sv
// Waveform table: synchronous RAM with one write port and one registered read port.
module dtpf_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int IDX_W       = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [15:0]      wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [15:0]      rd_data_r
);

  logic [15:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/dtpf_ctrl.sv
// Request decode, configuration registers, playback state and first pipeline stage.
module dtpf_ctrl #(
  parameter int IDX_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_addr,
  input  logic [31:0]           cfg_wr_data,
  input  logic                  in_accept,
  input  logic [1:0]            req_type,
  input  logic [15:0]           left_sample,
  input  logic                  left_valid,
  input  logic [15:0]           right_sample,
  input  logic                  right_valid,
  input  logic                  stream_ended,
  input  logic [7:0]            table_index,
  input  logic [15:0]           table_value,
  input  logic                  s1_adv,
  output logic                  mem_wr_en,
  output logic [IDX_W-1:0]      mem_wr_addr,
  output logic [15:0]           mem_wr_data,
  output logic                  mem_rd_en,
  output logic [IDX_W-1:0]      mem_rd_addr,
  output dtpf_pkg::dtpf_s1_t    s1_r,
  output dtpf_pkg::dtpf_status_t status
);

  logic        play_mode_r;
  logic [31:0] phase_inc_r;
  logic [23:0] tone_count_r;
  logic [31:0] wave_bytes_r;
  logic        stereo_r;

  logic        tone_active_r, tone_active_nxt;
  logic        wave_active_r, wave_active_nxt;
  logic [31:0] phase_r, phase_nxt;
  logic [23:0] remain_r, remain_nxt;
  logic [31:0] bytes_r, bytes_nxt;
  logic        s1_valid_r;
  logic        has_res;
  logic [32:0] bytes_sum;
  logic [15:0] pcm_sample;
  dtpf_pkg::dtpf_s1_t s1_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_mode_r  <= 1'b0;
      phase_inc_r  <= '0;
      tone_count_r <= 24'd1;
      wave_bytes_r <= '0;
      stereo_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (dtpf_pkg::dtpf_cfg_idx_t'(cfg_addr))
        dtpf_pkg::CFG_PLAY_MODE:  play_mode_r  <= cfg_wr_data[0];
        dtpf_pkg::CFG_PHASE_INC:  phase_inc_r  <= cfg_wr_data;
        dtpf_pkg::CFG_TONE_COUNT: tone_count_r <= cfg_wr_data[23:0];
        dtpf_pkg::CFG_WAVE_BYTES: wave_bytes_r <= cfg_wr_data;
        dtpf_pkg::CFG_STEREO:     stereo_r     <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  assign bytes_sum  = {1'b0, bytes_r} + (stereo_r ? 33'd4 : 33'd2);
  assign pcm_sample = (stereo_r && right_valid) ?
                      dtpf_pkg::avg_trunc(left_sample, right_sample) : left_sample;

  assign mem_wr_addr = IDX_W'(table_index);
  assign mem_wr_data = table_value;

  always_comb begin
    tone_active_nxt = tone_active_r;
    wave_active_nxt = wave_active_r;
    phase_nxt       = phase_r;
    remain_nxt      = remain_r;
    bytes_nxt       = bytes_r;
    has_res         = 1'b0;
    mem_wr_en       = 1'b0;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = phase_r[16 +: IDX_W];
    s1_nxt          = '0;
    s1_nxt.code     = dtpf_pkg::DAC_MID;
    if (in_accept) begin
      unique case (dtpf_pkg::dtpf_req_t'(req_type))
        dtpf_pkg::REQ_WRITE: begin
          mem_wr_en = 1'b1;
        end
        dtpf_pkg::REQ_STOP: begin
          tone_active_nxt = 1'b0;
          wave_active_nxt = 1'b0;
          remain_nxt      = '0;
          bytes_nxt       = '0;
          has_res         = 1'b1;
        end
        dtpf_pkg::REQ_START: begin
          remain_nxt = '0;
          bytes_nxt  = '0;
          has_res    = 1'b1;
          if (!play_mode_r) begin
            tone_active_nxt  = 1'b1;
            wave_active_nxt  = 1'b0;
            phase_nxt        = phase_inc_r;
            remain_nxt       = (tone_count_r == '0) ? '0 : tone_count_r - 24'd1;
            mem_rd_en        = 1'b1;
            mem_rd_addr      = '0;
            s1_nxt.use_table = 1'b1;
          end else begin
            tone_active_nxt = 1'b0;
            wave_active_nxt = 1'b1;
          end
        end
        dtpf_pkg::REQ_TICK: begin
          if (tone_active_r) begin
            has_res = 1'b1;
            if (remain_r == '0) begin
              tone_active_nxt  = 1'b0;
              s1_nxt.tone_done = 1'b1;
            end else begin
              mem_rd_en        = 1'b1;
              s1_nxt.use_table = 1'b1;
              phase_nxt        = phase_r + phase_inc_r;
              remain_nxt       = remain_r - 24'd1;
            end
          end else if (wave_active_r) begin
            has_res = 1'b1;
            if (bytes_r >= wave_bytes_r) begin
              wave_active_nxt  = 1'b0;
              s1_nxt.wave_done = 1'b1;
            end else if (!left_valid) begin
              if (stream_ended) begin
                wave_active_nxt  = 1'b0;
                s1_nxt.wave_done = 1'b1;
              end
            end else begin
              s1_nxt.code = dtpf_pkg::to_dac12(pcm_sample);
              bytes_nxt   = bytes_sum[32] ? '1 : bytes_sum[31:0];
            end
          end
        end
        default: ;
      endcase
    end
    s1_nxt.busy = tone_active_nxt | wave_active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_active_r <= 1'b0;
      wave_active_r <= 1'b0;
      phase_r       <= '0;
      remain_r      <= '0;
      bytes_r       <= '0;
      s1_valid_r    <= 1'b0;
    end else begin
      tone_active_r <= tone_active_nxt;
      wave_active_r <= wave_active_nxt;
      phase_r       <= phase_nxt;
      remain_r      <= remain_nxt;
      bytes_r       <= bytes_nxt;
      if (in_accept) begin
        s1_valid_r <= has_res;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= s1_nxt;
    end
  end

  assign status.tone_active = tone_active_r;
  assign status.wave_active = wave_active_r;
  assign status.s1_valid    = s1_valid_r;

endmodule

// File: rtl/dtpf_out.sv
// Table sample conversion and output register of the result channel.
module dtpf_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  input  dtpf_pkg::dtpf_s1_t s1,
  input  logic [15:0]        rd_data,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [11:0]        dac_code,
  output logic               tone_done,
  output logic               wave_done,
  output logic               busy_res,
  output logic               s1_adv
);

  logic        out_valid_r;
  logic [11:0] code_r;
  logic        tone_done_r;
  logic        wave_done_r;
  logic        busy_r;
  logic [11:0] code_nxt;

  assign s1_adv   = !out_valid_r || out_tready;
  assign code_nxt = s1.use_table ? dtpf_pkg::to_dac12(rd_data) : s1.code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      code_r      <= code_nxt;
      tone_done_r <= s1.tone_done;
      wave_done_r <= s1.wave_done;
      busy_r      <= s1.busy;
    end
  end

  assign out_tvalid = out_valid_r;
  assign dac_code   = code_r;
  assign tone_done  = tone_done_r;
  assign wave_done  = wave_done_r;
  assign busy_res   = busy_r;

endmodule

// File: rtl/dds_tone_and_pcm_dac_feeder_core.sv
// Top level of the DDS tone and PCM DAC feeder core.
// Takes one request word per clock while in_tready is high and returns at most one DAC word for
// it through the first-stage register and then the output register; the waveform table is a
// synchronous RAM with one write port and one registered read port, read in the accept cycle
// and converted as the first stage advances into the output register. Table writes and ticks
// with no active playback return no word. TABLE_DEPTH must be a power of two from 16 to 4096;
// entries never written read as undefined. No clearing pass is run after reset.
`include "dds_tone_and_pcm_dac_feeder_core_macros.svh"
module dds_tone_and_pcm_dac_feeder_core #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] left_sample, [31:16] right_sample, [39:32] table_index, [55:40] table_value
  input  logic [55:0] in_tdata,
  // [1:0] req_type, [2] left_valid, [3] right_valid
  input  logic [3:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [11:0] dac_code, [15:12] zero
  output logic [15:0] out_tdata,
  // [0] tone_done, [1] wave_done, [2] busy_res
  output logic [2:0]  out_tuser
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic                   in_accept;
  logic                   s1_adv;
  logic                   mem_wr_en;
  logic [IDX_W-1:0]       mem_wr_addr;
  logic [15:0]            mem_wr_data;
  logic                   mem_rd_en;
  logic [IDX_W-1:0]       mem_rd_addr;
  logic [15:0]            mem_rd_data;
  logic [11:0]            dac_code;
  logic                   tone_done;
  logic                   wave_done;
  logic                   busy_res;
  dtpf_pkg::dtpf_s1_t     s1;
  dtpf_pkg::dtpf_status_t status;

  assign in_tready = !status.s1_valid || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  dtpf_ctrl #(
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wr_data  (cfg_wr_data),
    .in_accept    (in_accept),
    .req_type     (in_tuser[1:0]),
    .left_sample  (in_tdata[15:0]),
    .left_valid   (in_tuser[2]),
    .right_sample (in_tdata[31:16]),
    .right_valid  (in_tuser[3]),
    .stream_ended (in_tlast),
    .table_index  (in_tdata[39:32]),
    .table_value  (in_tdata[55:40]),
    .s1_adv       (s1_adv),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .s1_r         (s1),
    .status       (status)
  );

  dtpf_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_en     (mem_rd_en),
    .rd_addr   (mem_rd_addr),
    .rd_data_r (mem_rd_data)
  );

  dtpf_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (status.s1_valid),
    .s1         (s1),
    .rd_data    (mem_rd_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .dac_code   (dac_code),
    .tone_done  (tone_done),
    .wave_done  (wave_done),
    .busy_res   (busy_res),
    .s1_adv     (s1_adv)
  );

  assign out_tdata = {4'd0, dac_code};
  assign out_tuser = {busy_res, wave_done, tone_done};

  `DTPF_CHECK(a_modes_exclusive, 1'b1, !(status.tone_active && status.wave_active))
  `DTPF_CHECK_NEXT(a_stop_clears, in_accept && (in_tuser[1:0] == dtpf_pkg::REQ_STOP), !status.tone_active && !status.wave_active)
  `DTPF_CHECK(a_done_not_busy, out_tvalid && (out_tuser[0] || out_tuser[1]), !out_tuser[2])
  `DTPF_CHECK_NEXT(a_idle_tick_silent, in_accept && (in_tuser[1:0] == dtpf_pkg::REQ_TICK) && !status.tone_active && !status.wave_active, !status.s1_valid)

endmodule
